### rtl/smf_pkg.sv
package smf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_W       = 4;
    localparam int LAG_W       = 3;
    localparam int SEEN_W      = 4;
    localparam int LEN_CAP     = 15;

    localparam logic [CFG_W-1:0]  LEN_RESET = 4'd5;
    localparam logic [SEEN_W-1:0] SEEN_MAX  = 4'd15;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    end_of_stream;
    } t_in_beat;

    typedef struct packed {
        t_sample median_value;
        logic    final_result;
    } t_out_beat;

    // store shift control, shared by every storage cell
    typedef struct packed {
        logic shift;
        logic fill;
    } t_cell_ctl;

    // pipeline advance strobes, shared by every rank lane
    typedef struct packed {
        logic adv_a;
        logic adv_b;
    } t_lane_ctl;

endpackage

### rtl/smf_cell.sv
module smf_cell
    import smf_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_sample   i_sample,
    input  t_sample   i_prev,
    output t_sample   o_value
);

    t_sample r_value;

    // first sample of a stream fills the whole row, otherwise take the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= i_ctl.fill ? i_sample : i_prev;
        end
    end

    assign o_value = r_value;

endmodule

### rtl/smf_rank_lane.sv
module smf_rank_lane
    import smf_pkg::*;
#(
    parameter int N    = 15,
    parameter int LANE = 0
) (
    input  logic             i_clk,
    input  t_lane_ctl        i_ctl,
    input  logic [CFG_W-1:0] i_len,
    input  logic [LAG_W-1:0] i_mid,
    input  t_sample          i_buf [N],
    output logic             o_hit
);

    localparam int CNT_W = $clog2(N + 1);
    localparam int CW    = (CNT_W > LAG_W) ? CNT_W : LAG_W;

    logic [N-1:0]     n_below;
    logic [N-1:0]     r_below;
    logic             r_own;
    logic             r_hit;
    logic [CNT_W-1:0] w_cnt;

    // entry k ranks below this lane if smaller, or equal and at a lower window position
    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (k == LANE) begin
                n_below[k] = 1'b0;
            end else if (k < LANE) begin
                n_below[k] = (i_len > CFG_W'(k)) && (i_buf[k] <= i_buf[LANE]);
            end else begin
                n_below[k] = (i_len > CFG_W'(k)) && (i_buf[k] < i_buf[LANE]);
            end
        end
    end

    always_comb begin
        w_cnt = '0;
        for (int k = 0; k < N; k++) begin
            w_cnt = w_cnt + CNT_W'(r_below[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_a) begin
            r_below <= n_below;
            r_own   <= i_len > CFG_W'(LANE);
        end
        if (i_ctl.adv_b) begin
            r_hit <= r_own && (CW'(w_cnt) == CW'(i_mid));
        end
    end

    assign o_hit = r_hit;

endmodule

### rtl/sliding_median_filter.sv
// Path: a window's beat goes through the issue slot, rank stages A and B, then the output register.
// Throughput: one beat per cycle unless the output stalls; a beat marked end_of_stream holds
// the input stalled while the single issue slot feeding the rank lanes flushes 1 to 8 results.
// Reset: synchronous, active low; window length returns to 5, the stream state empties and
// every pipeline stage and the output register drop their beats.
module sliding_median_filter
    import smf_pkg::*;
#(
    parameter int MAX_WINDOW = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_beat         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_beat        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // cells actually reachable by a 4-bit window length
    localparam int WIN_N = (MAX_WINDOW < LEN_CAP) ? MAX_WINDOW : LEN_CAP;
    localparam int IDX_W = (WIN_N > 1) ? $clog2(WIN_N) : 1;
    localparam int DW    = (IDX_W > LAG_W) ? IDX_W : LAG_W;

    // configuration and stream state
    logic [CFG_W-1:0]  r_len;
    logic [SEEN_W-1:0] r_seen;
    logic [SEEN_W-1:0] w_seen_new;
    logic [CFG_W-1:0]  w_len_eff;
    logic [LAG_W-1:0]  w_lag;
    logic [LAG_W-1:0]  w_mid;
    logic [LAG_W-1:0]  w_first;
    logic              w_in_acc;

    // issue slot: one pending window beat, or a flush run
    logic              r_iss;
    logic              r_flush;
    logic [LAG_W-1:0]  r_m;
    logic [LAG_W-1:0]  r_lag;
    logic              w_iss_v;
    logic [LAG_W-1:0]  w_m;
    logic              w_fin;

    // storage row
    t_cell_ctl         w_cell_ctl;
    t_sample           w_store [WIN_N];
    t_sample           w_prev  [WIN_N];
    t_sample           w_iss_buf [WIN_N];

    // rank pipeline
    t_lane_ctl         w_lane_ctl;
    logic              w_en_a;
    logic              w_en_b;
    logic              w_en_c;
    logic              r_a_v;
    logic              r_a_fin;
    logic [LAG_W-1:0]  r_a_mid;
    t_sample           r_a_buf [WIN_N];
    logic              r_b_v;
    logic              r_b_fin;
    t_sample           r_b_buf [WIN_N];
    logic [WIN_N-1:0]  w_hit;
    t_sample           w_med;
    logic              r_out_v;
    t_out_beat         r_out;

    // ------------------------------------------------------------------
    // Window length: zero acts as one, anything past the row clamps to it.
    // lag = results still owed when the stream ends, mid = upper median rank.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_len == '0) begin
            w_len_eff = CFG_W'(1);
        end else if (r_len > CFG_W'(WIN_N)) begin
            w_len_eff = CFG_W'(WIN_N);
        end else begin
            w_len_eff = r_len;
        end
    end

    assign w_mid = w_len_eff[CFG_W-1:1];
    assign w_lag = LAG_W'(w_len_eff - CFG_W'(1) - (w_len_eff >> 1));

    // saturating count of beats in the current stream, this beat included
    assign w_seen_new = (r_seen == SEEN_MAX) ? r_seen : r_seen + SEEN_W'(1);

    // first flush offset: a short stream owes only one result per beat seen
    always_comb begin
        if (w_seen_new > SEEN_W'(w_lag)) begin
            w_first = '0;
        end else begin
            w_first = LAG_W'(SEEN_W'(w_lag) + SEEN_W'(1) - w_seen_new);
        end
    end

    // ------------------------------------------------------------------
    // Handshakes. Hold the input while flushing, and while a pending
    // window beat cannot enter the rank pipeline (the row must not move).
    // ------------------------------------------------------------------
    assign w_en_c     = !r_out_v || !i_out_stall;
    assign w_en_b     = !r_b_v || w_en_c;
    assign w_en_a     = !r_a_v || w_en_b;
    assign o_in_stall = r_flush || (r_iss && !w_en_a);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_len <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Storage row: newest sample in cell 0, advance one cell per beat.
    // ------------------------------------------------------------------
    assign w_cell_ctl.shift = w_in_acc;
    assign w_cell_ctl.fill  = (r_seen == '0);

    for (genvar c = 0; c < WIN_N; c++) begin : g_cell
        if (c == 0) begin : g_head
            assign w_prev[c] = i_in_data.sample;
        end else begin : g_body
            assign w_prev[c] = w_store[c-1];
        end

        smf_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_cell_ctl),
            .i_sample (i_in_data.sample),
            .i_prev   (w_prev[c]),
            .o_value  (w_store[c])
        );
    end

    // ------------------------------------------------------------------
    // Issue slot. A normal beat that completes a window waits here until
    // stage A takes it; the last beat issues lag+1 windows (fewer on a short stream),
    // each with the newest sample repeated m more times past the end.
    // ------------------------------------------------------------------
    assign w_iss_v = r_iss || r_flush;
    assign w_m     = r_flush ? r_m : '0;
    assign w_fin   = r_flush && (r_m == r_lag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_iss   <= 1'b0;
            r_flush <= 1'b0;
        end else if (w_in_acc) begin
            if (i_in_data.end_of_stream) begin
                // drop the stream state now; the row holds until the flush ends
                r_seen  <= '0;
                r_iss   <= 1'b0;
                r_flush <= 1'b1;
                r_m     <= w_first;
                r_lag   <= w_lag;
            end else begin
                r_seen <= w_seen_new;
                r_iss  <= w_seen_new > SEEN_W'(w_lag);
            end
        end else begin
            if (w_en_a) begin
                r_iss <= 1'b0;
            end
            if (r_flush && w_en_a) begin
                if (r_m == r_lag) begin
                    r_flush <= 1'b0;
                end else begin
                    r_m <= r_m + LAG_W'(1);
                end
            end
        end
    end

    // window position j reads the row at j-m, the newest cell where j < m
    always_comb begin
        logic [DW-1:0] jv;
        logic [DW-1:0] mv;
        logic [DW-1:0] dv;
        for (int j = 0; j < WIN_N; j++) begin
            jv = DW'(j);
            mv = DW'(w_m);
            dv = (jv >= mv) ? jv - mv : '0;
            w_iss_buf[j] = w_store[dv[IDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Rank pipeline. Stage A: every lane compares its entry against the
    // whole window. Stage B: count and match the median rank. Then the
    // one hitting lane drives the output register.
    // ------------------------------------------------------------------
    assign w_lane_ctl.adv_a = w_en_a;
    assign w_lane_ctl.adv_b = w_en_b;

    for (genvar j = 0; j < WIN_N; j++) begin : g_lane
        smf_rank_lane #(
            .N    (WIN_N),
            .LANE (j)
        ) u_lane (
            .i_clk (i_clk),
            .i_ctl (w_lane_ctl),
            .i_len (w_len_eff),
            .i_mid (r_a_mid),
            .i_buf (w_iss_buf),
            .o_hit (w_hit[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_buf <= w_iss_buf;
            r_a_mid <= w_mid;
            r_a_fin <= w_fin;
        end
        if (w_en_b) begin
            r_b_buf <= r_a_buf;
            r_b_fin <= r_a_fin;
        end
        if (w_en_c && r_b_v) begin
            r_out.median_value <= w_med;
            r_out.final_result <= r_b_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_a_v <= w_iss_v;
            end
            if (w_en_b) begin
                r_b_v <= r_a_v;
            end
            if (w_en_c) begin
                r_out_v <= r_b_v;
            end
        end
    end

    // exactly one lane matches the median rank
    always_comb begin
        w_med = '0;
        for (int j = 0; j < WIN_N; j++) begin
            if (w_hit[j]) begin
                w_med = w_med | r_b_buf[j];
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import smf_pkg::*;

    // Store depth of the block; the window length can never exceed it.
    localparam int          MAX_WIN       = LEN_CAP;
    // Leave a margin after the last result before touching the register.
    localparam int          SETTLE_CYCLES = 8;
    localparam int          RANDOM_ITEMS  = 150;
    localparam int          REPORT_LIMIT  = 10;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_beat         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_beat        o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    // Predicted state of the filter: newest sample at index 0.
    t_sample           recent_samples [MAX_WIN];
    logic [SEEN_W-1:0] stream_count;
    logic [CFG_W-1:0]  win_len_now = LEN_RESET;

    // Medians still owed by the block, oldest first.
    t_out_beat         expected_medians [$];
    t_out_beat         want_beat;

    int unsigned       mismatch_count = 0;
    // When set, both sides stop idling between beats.
    bit                no_idle        = 1'b0;
    // Cycles for the receiver to hold off on its next beat; zero when unused.
    int unsigned       long_hold      = 0;

    sliding_median_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Median predictor
    // ------------------------------------------------------------------

    // Empty the stream: zero the store and the sample count.
    function automatic void clear_stream();
        foreach (recent_samples[i]) recent_samples[i] = '0;
        stream_count = '0;
    endfunction

    // Append one owed median at the tail of the queue.
    function automatic void queue_median(input t_out_beat med);
        expected_medians.insert(expected_medians.size(), med);
    endfunction

    // Median of a len-sample window whose newest sample is repeated
    // 'repeats' times past the end of the stream.
    function automatic t_sample window_median(input int unsigned len,
                                              input int unsigned repeats);
        t_sample     ordered [MAX_WIN];
        t_sample     v;
        int unsigned d;
        int          k;
        for (int j = 0; j < len; j++) begin
            // Offsets that fall past the end of the stream take the newest sample.
            d = (j >= repeats) ? (j - repeats) : 0;
            if (d >= MAX_WIN) d = MAX_WIN - 1;
            ordered[j] = recent_samples[d];
        end
        for (int i = 1; i < len; i++) begin
            v = ordered[i];
            k = i;
            while (k > 0 && ordered[k-1] > v) begin
                ordered[k] = ordered[k-1];
                k--;
            end
            ordered[k] = v;
        end
        // Upper median for an even length.
        return ordered[len / 2];
    endfunction

    // Advance the predicted state by one accepted beat and queue its medians.
    function automatic void predict_medians(input t_in_beat beat);
        int unsigned len;
        int unsigned lag;
        int unsigned first;
        t_out_beat   med;
        // A zero length acts as one.
        len = (win_len_now == '0) ? 1 : win_len_now;
        if (len > MAX_WIN) len = MAX_WIN;
        lag = len - 1 - len / 2;

        // The first sample of a stream fills the whole store.
        if (stream_count == '0) begin
            foreach (recent_samples[i]) recent_samples[i] = beat.sample;
        end else begin
            for (int i = MAX_WIN - 1; i > 0; i--) recent_samples[i] = recent_samples[i-1];
            recent_samples[0] = beat.sample;
        end
        if (stream_count < SEEN_MAX) stream_count++;

        if (!beat.end_of_stream) begin
            if (stream_count > lag) begin
                med.median_value = window_median(len, 0);
                med.final_result = 1'b0;
                queue_median(med);
            end
        end else begin
            // Flush every position still owed; a short stream owes one per sample.
            first = (stream_count > lag) ? 0 : lag + 1 - stream_count;
            for (int unsigned m = first; m <= lag; m++) begin
                med.median_value = window_median(len, m);
                med.final_result = (m == lag);
                queue_median(med);
            end
            clear_stream();
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker: sample at the rising edge, compare with the oldest median
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input t_out_beat want,
                                 input t_out_beat got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected median %0d final %b, got median %0d final %b",
                     $time, what, want.median_value, want.final_result,
                     got.median_value, got.final_result);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_medians.size() == 0) begin
                note_mismatch("beat with no median pending", 'x, o_out_data);
            end else begin
                want_beat = expected_medians.pop_front();
                if (o_out_data.median_value !== want_beat.median_value ||
                    o_out_data.final_result !== want_beat.final_result) begin
                    note_mismatch("median beat differs", want_beat, o_out_data);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    function automatic int unsigned pick_gap();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    // Receiver: before each beat, stall for a random count of cycles, or for
    // the long hold when one is requested, then take the beat.
    initial begin : out_side
        int unsigned wait_n;
        forever begin
            if (long_hold != 0) begin
                wait_n    = long_hold;
                long_hold = 0;
            end else begin
                wait_n = pick_gap();
            end
            @(negedge i_clk);
            if (wait_n != 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid && !i_out_stall));
        end
    end

    // Offer one sample after a random gap and hold it until accepted.
    // Leave valid high on return so back-to-back beats need no bubble.
    task automatic send_sample(input t_sample value, input logic last);
        t_in_beat    beat;
        int unsigned gap;
        beat.sample        = value;
        beat.end_of_stream = last;
        gap = pick_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        predict_medians(beat);
    endtask

    // Drop valid, wait for every owed median, then let the pipeline settle.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_medians.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the window length once the block has gone quiet.
    task automatic write_window_len(input logic [CFG_W-1:0] len);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        win_len_now = len;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_sample draw_sample();
        // Bias toward the ends of the range so ties and extremes show up often.
        case ($urandom_range(0, 3))
            0:       return t_sample'($urandom_range(0, 3));
            1:       return 16'hFFFF - t_sample'($urandom_range(0, 3));
            default: return t_sample'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Window length after reset, extreme sample values.
    task automatic test_default_length();
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        wait_idle();
    endtask

    // Stream of one sample: every answer comes at the final beat.
    task automatic test_lone_sample();
        send_sample(16'hFFFF, 1'b1);
        wait_idle();
    endtask

    // Stream that ends before the first answer is due.
    task automatic test_short_stream();
        send_sample(16'h1234, 1'b0);
        send_sample(16'h0000, 1'b1);
        wait_idle();
    endtask

    // A zero length acts as one.
    task automatic test_zero_length();
        write_window_len('0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b1);
        wait_idle();
    endtask

    // Longest window: the final beat flushes the most answers.
    task automatic test_longest_window();
        write_window_len(CFG_W'(LEN_CAP));
        for (int i = 0; i < 9; i++) begin
            send_sample((i % 2 == 0) ? 16'hFFFF - 16'(i) : 16'(i * 3), i == 8);
        end
        wait_idle();
    endtask

    // Even length, then a new length in the middle of the stream.
    task automatic test_length_change_midstream();
        write_window_len(4'd4);
        send_sample(16'h0400, 1'b0);
        send_sample(16'h0100, 1'b0);
        write_window_len(4'd6);
        send_sample(16'hFF00, 1'b0);
        send_sample(16'h0200, 1'b1);
        wait_idle();
    endtask

    // Hold the output off for a long stretch while samples keep coming,
    // so the block fills up and stalls its input.
    task automatic test_output_backpressure();
        write_window_len(4'd7);
        no_idle   = 1'b1;
        long_hold = 80;
        for (int i = 0; i < 30; i++) send_sample(draw_sample(), i == 29);
        no_idle = 1'b0;
        wait_idle();
    endtask

    // Random streams of random length under random window lengths.
    task automatic test_random_streams();
        int unsigned      sent;
        int unsigned      run_len;
        int unsigned      streams;
        logic [CFG_W-1:0] len_pick;
        sent    = 0;
        streams = 0;
        while (sent < RANDOM_ITEMS) begin
            no_idle  = ($urandom_range(0, 3) == 0);
            // Start at the shortest window, then draw over the whole field.
            len_pick = (streams == 0) ? 4'd1 : CFG_W'($urandom_range(0, 15));
            write_window_len(len_pick);
            run_len = $urandom_range(1, 20);
            for (int unsigned k = 0; k < run_len; k++) begin
                // Now and then retune the window partway through a stream.
                if (k == run_len / 2 && k != 0 && $urandom_range(0, 4) == 0) begin
                    write_window_len(CFG_W'($urandom_range(0, 15)));
                end
                send_sample(draw_sample(), k == run_len - 1);
                sent++;
            end
            streams++;
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        clear_stream();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_length();
        test_lone_sample();
        test_short_stream();
        test_zero_length();
        test_longest_window();
        test_length_change_midstream();
        test_output_backpressure();
        test_random_streams();

        wait_idle();
        if (mismatch_count == 0 && expected_medians.size() == 0) begin
            $display("sliding_median_filter: match");
        end else begin
            $display("sliding_median_filter: mismatch");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #20_000_000;
        $display("sliding_median_filter: mismatch");
        $finish;
    end

endmodule
